// ===== design/utld_pkg.sv =====
`default_nettype none
package utld_pkg;

  localparam int unsigned HourW  = 5;
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 7;
  localparam int unsigned OffW   = 5;

  localparam logic [MonthW-1:0] MonJan = 4'd1;
  localparam logic [MonthW-1:0] MonFeb = 4'd2;
  localparam logic [MonthW-1:0] MonMar = 4'd3;
  localparam logic [MonthW-1:0] MonNov = 4'd11;
  localparam logic [MonthW-1:0] MonDec = 4'd12;
  localparam logic [YearW-1:0]  YearMax = 7'd99;
  localparam logic [HourW-1:0]  HoursPerDay = 5'd24;
  localparam logic [HourW-1:0]  DstHour = 5'd2;
  localparam logic [DayW-1:0]   FebDays = 5'd28;

  // month key for March and November (both 4) plus century key for 2000s (6) plus one
  localparam logic [7:0] MarNovKeySum = 8'd11;

  typedef enum logic [1:0] {
    ROLL_NONE = 2'd0,
    ROLL_BACK = 2'd1,
    ROLL_FWD  = 2'd2
  } roll_t;

  typedef struct packed {
    logic [HourW-1:0]  hour;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } stamp_t;

  typedef struct packed {
    logic   valid;
    roll_t  roll;
    stamp_t ts;
  } front_t;

  typedef struct packed {
    logic   valid;
    stamp_t ts;
  } local_t;

  function automatic logic [DayW-1:0] month_length(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd2:    len = FebDays;
      default: len = 5'd30;
    endcase
    return len;
  endfunction

  // 8 and 64 are both 1 mod 7, so fold octal digits
  function automatic logic [2:0] mod7(input logic [7:0] s);
    logic [4:0] t;
    logic [3:0] u;
    logic [3:0] r;
    t = {3'b000, s[7:6]} + {2'b00, s[5:3]} + {2'b00, s[2:0]};
    u = {2'b00, t[4:3]} + {1'b0, t[2:0]};
    r = (u >= 4'd7) ? (u - 4'd7) : u;
    return r[2:0];
  endfunction

  // weekday code of the 1st: saturday 0, sunday 1, ...
  function automatic logic [DayW-1:0] first_sunday(input logic [2:0] dow);
    logic [DayW-1:0] d;
    case (dow)
      3'd0:    d = 5'd2;
      3'd1:    d = 5'd1;
      3'd2:    d = 5'd7;
      3'd3:    d = 5'd6;
      3'd4:    d = 5'd5;
      3'd5:    d = 5'd4;
      3'd6:    d = 5'd3;
      default: d = 5'd1;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== design/utld_front.sv =====
`default_nettype none
module utld_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire utld_pkg::stamp_t              in_ts,
  input  wire logic [utld_pkg::OffW-1:0]     offset,
  output utld_pkg::front_t                   out
);

  utld_pkg::front_t front_r;
  utld_pkg::front_t front_nxt;

  logic signed [6:0] hsum;

  always_comb begin
    hsum = $signed({2'b00, in_ts.hour}) + $signed({{2{offset[utld_pkg::OffW-1]}}, offset});
    front_nxt       = front_r;
    front_nxt.valid = in_valid;
    front_nxt.ts    = in_ts;
    if (hsum < 7'sd0) begin
      front_nxt.roll    = utld_pkg::ROLL_BACK;
      front_nxt.ts.hour = utld_pkg::HourW'(hsum + 7'sd24);
    end else if (hsum > 7'sd23) begin
      front_nxt.roll    = utld_pkg::ROLL_FWD;
      front_nxt.ts.hour = utld_pkg::HourW'(hsum - 7'sd24);
    end else begin
      front_nxt.roll    = utld_pkg::ROLL_NONE;
      front_nxt.ts.hour = utld_pkg::HourW'(hsum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r.valid <= 1'b0;
    end else begin
      front_r.valid <= front_nxt.valid;
    end
    front_r.roll <= front_nxt.roll;
    front_r.ts   <= front_nxt.ts;
  end

  assign out = front_r;

endmodule
`default_nettype wire

// ===== design/utld_roll.sv =====
`default_nettype none
module utld_roll (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire utld_pkg::front_t in,
  output utld_pkg::local_t      out
);

  utld_pkg::local_t loc_r;
  utld_pkg::local_t loc_nxt;

  logic [utld_pkg::MonthW-1:0] prev_month;
  logic [utld_pkg::DayW:0]     day_inc;

  always_comb begin
    prev_month = in.ts.month - 4'd1;
    day_inc    = {1'b0, in.ts.day} + 6'd1;
    loc_nxt       = loc_r;
    loc_nxt.valid = in.valid;
    loc_nxt.ts    = in.ts;
    case (in.roll)
      utld_pkg::ROLL_BACK: begin
        if (in.ts.day <= 5'd1) begin
          if (in.ts.month <= utld_pkg::MonJan) begin
            loc_nxt.ts.month = utld_pkg::MonDec;
            loc_nxt.ts.day   = 5'd31;
            loc_nxt.ts.year  = (in.ts.year == '0) ? utld_pkg::YearMax : in.ts.year - 7'd1;
          end else begin
            loc_nxt.ts.month = prev_month;
            loc_nxt.ts.day   = utld_pkg::month_length(prev_month);
          end
        end else begin
          loc_nxt.ts.day = in.ts.day - 5'd1;
        end
      end
      utld_pkg::ROLL_FWD: begin
        if (day_inc > {1'b0, utld_pkg::month_length(in.ts.month)}) begin
          loc_nxt.ts.day = 5'd1;
          if (in.ts.month >= utld_pkg::MonDec) begin
            loc_nxt.ts.month = utld_pkg::MonJan;
            loc_nxt.ts.year  = (in.ts.year >= utld_pkg::YearMax) ? '0 : in.ts.year + 7'd1;
          end else begin
            loc_nxt.ts.month = in.ts.month + 4'd1;
          end
        end else begin
          loc_nxt.ts.day = day_inc[utld_pkg::DayW-1:0];
        end
      end
      default: begin
        loc_nxt.ts = in.ts;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loc_r.valid <= 1'b0;
    end else begin
      loc_r.valid <= loc_nxt.valid;
    end
    loc_r.ts <= loc_nxt.ts;
  end

  assign out = loc_r;

endmodule
`default_nettype wire

// ===== design/utld_dst.sv =====
`default_nettype none
module utld_dst (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire utld_pkg::local_t      in,
  output utld_pkg::local_t           out,
  output logic                       dst_active
);

  utld_pkg::local_t              sun_loc_r;
  logic [utld_pkg::DayW-1:0]     sunday_r;
  logic [utld_pkg::DayW-1:0]     sunday_nxt;
  logic [7:0]                    key_sum;

  utld_pkg::local_t              out_loc_r;
  logic                          dst_r;
  logic                          dst_nxt;
  logic [utld_pkg::DayW-1:0]     mar_sunday;

  function automatic logic [4:0] sun_src_year(input logic [utld_pkg::YearW-1:0] y);
    return y[utld_pkg::YearW-1:2];
  endfunction

  // first sunday of march or november, same key for both months
  always_comb begin
    key_sum    = {3'b000, sun_src_year(in.ts.year)} + {1'b0, in.ts.year}
                 + utld_pkg::MarNovKeySum;
    sunday_nxt = utld_pkg::first_sunday(utld_pkg::mod7(key_sum));
  end

  always_comb begin
    mar_sunday = sunday_r + 5'd7;
    dst_nxt    = 1'b0;
    if (sun_loc_r.ts.month == utld_pkg::MonNov) begin
      if (sun_loc_r.ts.day < sunday_r) begin
        dst_nxt = 1'b1;
      end else if (sun_loc_r.ts.day > sunday_r) begin
        dst_nxt = 1'b0;
      end else begin
        dst_nxt = (sun_loc_r.ts.hour < utld_pkg::DstHour);
      end
    end else if (sun_loc_r.ts.month == utld_pkg::MonMar) begin
      if (sun_loc_r.ts.day < mar_sunday) begin
        dst_nxt = 1'b0;
      end else if (sun_loc_r.ts.day > mar_sunday) begin
        dst_nxt = 1'b1;
      end else begin
        dst_nxt = (sun_loc_r.ts.hour >= utld_pkg::DstHour);
      end
    end else if (sun_loc_r.ts.month > utld_pkg::MonMar &&
                 sun_loc_r.ts.month < utld_pkg::MonNov) begin
      dst_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sun_loc_r.valid <= 1'b0;
      out_loc_r.valid <= 1'b0;
    end else begin
      sun_loc_r.valid <= in.valid;
      out_loc_r.valid <= sun_loc_r.valid;
    end
    sun_loc_r.ts <= in.ts;
    sunday_r     <= sunday_nxt;
    out_loc_r.ts <= sun_loc_r.ts;
    dst_r        <= dst_nxt;
  end

  assign out        = out_loc_r;
  assign dst_active = dst_r;

endmodule
`default_nettype wire

// ===== design/utc_to_local_with_dst_core.sv =====
// utc to local time with us daylight-saving flag
// a word accepted on start is strobed on out_valid after the stages below
// throughput: one word per cycle, busy stays low; the four register stages
// (offset add, date rollover, sunday search, dst compare) never stall
// reset: synchronous active-low rst_n clears all stage valid bits and sets
// the utc offset to 0
`default_nettype none
module utc_to_local_with_dst_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [utld_pkg::HourW-1:0]      in_utc_hour,
  input  wire logic [utld_pkg::DayW-1:0]       in_utc_day,
  input  wire logic [utld_pkg::MonthW-1:0]     in_utc_month,
  input  wire logic [utld_pkg::YearW-1:0]      in_utc_year,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [utld_pkg::OffW-1:0]       cfg_utc_offset,
  output logic                                 out_valid,
  output logic [utld_pkg::HourW-1:0]           out_local_hour,
  output logic [utld_pkg::DayW-1:0]            out_local_day,
  output logic [utld_pkg::MonthW-1:0]          out_local_month,
  output logic [utld_pkg::YearW-1:0]           out_local_year,
  output logic                                 out_dst_active
);

  logic [utld_pkg::OffW-1:0] offset_r;
  logic [utld_pkg::OffW-1:0] offset_nxt;

  utld_pkg::stamp_t in_ts;
  utld_pkg::front_t front;
  utld_pkg::local_t loc;
  utld_pkg::local_t res;
  logic             dst;
  logic             accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  always_comb begin
    offset_nxt = (cfg_valid && cfg_ready) ? cfg_utc_offset : offset_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
    end else begin
      offset_r <= offset_nxt;
    end
  end

  always_comb begin
    in_ts.hour  = in_utc_hour;
    in_ts.day   = in_utc_day;
    in_ts.month = in_utc_month;
    in_ts.year  = in_utc_year;
  end

  utld_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .in_ts    (in_ts),
    .offset   (offset_r),
    .out      (front)
  );

  utld_roll u_roll (
    .clk   (clk),
    .rst_n (rst_n),
    .in    (front),
    .out   (loc)
  );

  utld_dst u_dst (
    .clk        (clk),
    .rst_n      (rst_n),
    .in         (loc),
    .out        (res),
    .dst_active (dst)
  );

  assign out_valid       = res.valid;
  assign out_local_hour  = res.ts.hour;
  assign out_local_day   = res.ts.day;
  assign out_local_month = res.ts.month;
  assign out_local_year  = res.ts.year;
  assign out_dst_active  = dst;

endmodule
`default_nettype wire

// ===== test/tb_utc_to_local_with_dst_core.sv =====
`default_nettype none
module tb_utc_to_local_with_dst_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;
  localparam int SettleCycles = 8;
  localparam int NumDir = 25;
  localparam int NumPhases = 10;
  localparam int WordsPerPhase = 115;
  localparam int unsigned CenturyKey2000 = 6;
  localparam int unsigned MonthKey [12] = '{1, 4, 4, 0, 2, 5, 0, 3, 6, 1, 4, 6};
  localparam int PhaseOffsets [5] = '{-16, 15, -12, 14, 0};

  typedef struct packed {
    utld_pkg::stamp_t ts;
    logic             dst;
  } local_word_t;

  // typed rows carry the expected word, the rest go through the predictor
  typedef struct {
    int off;
    int hr;
    int dy;
    int mo;
    int yr;
    bit typed;
    int eh;
    int ed;
    int em;
    int ey;
    int edst;
  } dir_row_t;

  dir_row_t dir_rows [NumDir] = '{
    '{  0,  0,  1,  1,   0, 1,  0,  1,  1,  0, 0},
    '{  0, 23, 31, 12,  99, 1, 23, 31, 12, 99, 0},
    '{  0, 12, 15,  7,  50, 1, 12, 15,  7, 50, 1},
    '{  0,  1, 10,  3,  24, 1,  1, 10,  3, 24, 0},
    '{  0,  2, 10,  3,  24, 1,  2, 10,  3, 24, 1},
    '{  0,  1,  3, 11,  24, 1,  1,  3, 11, 24, 1},
    '{  0,  2,  3, 11,  24, 1,  2,  3, 11, 24, 0},
    '{  0,  2, 14,  3,   4, 0,  0,  0,  0,  0, 0},
    '{  0, 23, 13,  3,   4, 0,  0,  0,  0,  0, 0},
    '{  0, 31, 31, 15, 127, 0,  0,  0,  0,  0, 0},
    '{  0,  0,  0,  0,   0, 0,  0,  0,  0,  0, 0},
    '{ -1,  0,  1,  1,   0, 1, 23, 31, 12, 99, 0},
    '{ -1,  0,  1,  3,  24, 0,  0,  0,  0,  0, 0},
    '{ -1,  0,  1,  0,   5, 0,  0,  0,  0,  0, 0},
    '{ -1,  0,  0,  7, 100, 0,  0,  0,  0,  0, 0},
    '{ -1,  0,  1,  1, 100, 0,  0,  0,  0,  0, 0},
    '{-16,  0, 15,  6,  20, 1,  8, 14,  6, 20, 1},
    '{-16, 31, 31, 15, 127, 0,  0,  0,  0,  0, 0},
    '{  1, 23, 31, 12,  99, 1,  0,  1,  1,  0, 0},
    '{  1, 23, 28,  2,  24, 0,  0,  0,  0,  0, 0},
    '{  1, 23, 30, 13, 110, 0,  0,  0,  0,  0, 0},
    '{ 15, 23, 31, 12,  99, 0,  0,  0,  0,  0, 0},
    '{ 15, 11,  8, 11,   0, 0,  0,  0,  0,  0, 0},
    '{ 14,  0,  0,  9,  64, 0,  0,  0,  0,  0, 0},
    '{-12, 13, 10,  3,  24, 0,  0,  0,  0,  0, 0}
  };

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [utld_pkg::HourW-1:0] in_utc_hour;
  logic [utld_pkg::DayW-1:0] in_utc_day;
  logic [utld_pkg::MonthW-1:0] in_utc_month;
  logic [utld_pkg::YearW-1:0] in_utc_year;
  logic cfg_valid;
  logic cfg_ready;
  logic [utld_pkg::OffW-1:0] cfg_utc_offset;
  logic out_valid;
  logic [utld_pkg::HourW-1:0] out_local_hour;
  logic [utld_pkg::DayW-1:0] out_local_day;
  logic [utld_pkg::MonthW-1:0] out_local_month;
  logic [utld_pkg::YearW-1:0] out_local_year;
  logic out_dst_active;

  local_word_t pending_local [$];
  logic signed [utld_pkg::OffW-1:0] offset_now;
  bit start_level;
  int burst_left;
  int mismatches;
  int cycles;

  utc_to_local_with_dst_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_utc_hour    (in_utc_hour),
    .in_utc_day     (in_utc_day),
    .in_utc_month   (in_utc_month),
    .in_utc_year    (in_utc_year),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_utc_offset (cfg_utc_offset),
    .out_valid      (out_valid),
    .out_local_hour (out_local_hour),
    .out_local_day  (out_local_day),
    .out_local_month(out_local_month),
    .out_local_year (out_local_year),
    .out_dst_active (out_dst_active)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned days_in_month(input int unsigned m);
    int unsigned n;
    case (m)
      1, 3, 5, 7, 8, 10, 12: n = 31;
      2: n = 28;
      default: n = 30;
    endcase
    return n;
  endfunction

  // day of the first sunday in march or november, weekday of the 1st by month key
  function automatic int unsigned first_sunday_day(input int unsigned m, input int unsigned y);
    int unsigned dow;
    dow = (y / 4 + 1 + MonthKey[(m - 1) % 12] + CenturyKey2000 + y) % 7;
    return ((8 - dow) % 7) + 1;
  endfunction

  function automatic logic in_dst_window(input int unsigned h, input int unsigned d,
                                         input int unsigned m, input int unsigned y);
    int unsigned sun;
    if (m < 3 || m > 11) return 1'b0;
    if (m > 3 && m < 11) return 1'b1;
    if (m == 11) begin
      sun = first_sunday_day(11, y);
      if (d != sun) return d < sun;
      return h < 2;
    end
    sun = first_sunday_day(3, y) + 7;
    if (d != sun) return d > sun;
    return h >= 2;
  endfunction

  function automatic local_word_t to_local(input logic signed [utld_pkg::OffW-1:0] off,
                                           input utld_pkg::stamp_t u);
    int h;
    int o;
    int unsigned d;
    int unsigned m;
    int unsigned y;
    local_word_t r;
    o = off;
    h = int'(u.hour) + o;
    d = u.day;
    m = u.month;
    y = u.year;
    if (h < 0) begin
      h += 24;
      if (d <= 1) begin
        if (m <= 1) begin
          m = 12;
          d = 31;
          y = (y == 0) ? 99 : y - 1;
        end else begin
          m -= 1;
          d = days_in_month(m);
        end
      end else begin
        d -= 1;
      end
    end else if (h > 23) begin
      h -= 24;
      if (d + 1 > days_in_month(m)) begin
        d = 1;
        if (m >= 12) begin
          m = 1;
          y = (y >= 99) ? 0 : y + 1;
        end else begin
          m += 1;
        end
      end else begin
        d += 1;
      end
    end
    r.ts.hour = h[utld_pkg::HourW-1:0];
    r.ts.day = d[utld_pkg::DayW-1:0];
    r.ts.month = m[utld_pkg::MonthW-1:0];
    r.ts.year = y[utld_pkg::YearW-1:0];
    r.dst = in_dst_window(h, d, m, y);
    return r;
  endfunction

  // mostly legal stamps aimed at rollover and dst edges, some raw noise
  function automatic utld_pkg::stamp_t random_stamp();
    utld_pkg::stamp_t s;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    s.hour = utld_pkg::HourW'($urandom_range(0, 23));
    s.month = utld_pkg::MonthW'($urandom_range(1, 12));
    s.year = ($urandom_range(0, 9) == 0) ?
             (($urandom_range(0, 1) != 0) ? utld_pkg::YearMax : '0)
             : utld_pkg::YearW'($urandom_range(0, 99));
    s.day = utld_pkg::DayW'($urandom_range(1, days_in_month(s.month)));
    if (pick < 15) begin
      s = utld_pkg::stamp_t'($urandom);
    end else if (pick < 45) begin
      s.month = ($urandom_range(0, 1) != 0) ? utld_pkg::MonMar : utld_pkg::MonNov;
      s.day = utld_pkg::DayW'($urandom_range(1, 15));
    end else if (pick < 75) begin
      s.day = ($urandom_range(0, 1) != 0) ? 5'd1 : utld_pkg::DayW'(days_in_month(s.month));
      s.hour = ($urandom_range(0, 1) != 0) ? utld_pkg::HourW'($urandom_range(0, 3))
                                           : utld_pkg::HourW'($urandom_range(20, 23));
    end
    return s;
  endfunction

  task automatic set_start(input bit v);
    if (start_level != v) begin
      start <= v;
      start_level = v;
    end
  endtask

  task automatic wait_drained();
    set_start(1'b0);
    while (pending_local.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic load_offset(input logic [utld_pkg::OffW-1:0] v);
    wait_drained();
    cfg_utc_offset <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    offset_now = v;
  endtask

  task automatic send_word(input utld_pkg::stamp_t s, input bit typed, input local_word_t want);
    int gap;
    in_utc_hour <= s.hour;
    in_utc_day <= s.day;
    in_utc_month <= s.month;
    in_utc_year <= s.year;
    set_start(1'b1);
    do @(posedge clk); while (busy);
    pending_local.push_back(typed ? want : to_local(offset_now, s));
    burst_left--;
    if (burst_left <= 0) begin
      if ($urandom_range(0, 49) == 0) begin
        wait_drained();
      end else begin
        gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
        if (gap > 0) begin
          set_start(1'b0);
          repeat (gap) @(posedge clk);
        end
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
  endtask

  always @(posedge clk) begin
    local_word_t want;
    if (rst_n && out_valid) begin
      if (pending_local.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t unexpected local word", $time);
      end else begin
        want = pending_local.pop_front();
        if (out_local_hour !== want.ts.hour || out_local_day !== want.ts.day ||
            out_local_month !== want.ts.month || out_local_year !== want.ts.year ||
            out_dst_active !== want.dst) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t mismatch: exp %0d %0d/%0d/%0d dst %0d, got %0d %0d/%0d/%0d dst %0d",
                     $time, want.ts.hour, want.ts.day, want.ts.month, want.ts.year, want.dst,
                     out_local_hour, out_local_day, out_local_month, out_local_year,
                     out_dst_active);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    utld_pkg::stamp_t s;
    local_word_t want;
    logic [utld_pkg::OffW-1:0] off;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_utc_hour <= '0;
    in_utc_day <= '0;
    in_utc_month <= '0;
    in_utc_year <= '0;
    cfg_valid <= 1'b0;
    cfg_utc_offset <= '0;
    start_level = 1'b0;
    offset_now = '0;
    mismatches = 0;
    cycles = 0;
    burst_left = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NumDir; i++) begin
      if (int'(offset_now) != dir_rows[i].off)
        load_offset(utld_pkg::OffW'(dir_rows[i].off));
      s.hour = utld_pkg::HourW'(dir_rows[i].hr);
      s.day = utld_pkg::DayW'(dir_rows[i].dy);
      s.month = utld_pkg::MonthW'(dir_rows[i].mo);
      s.year = utld_pkg::YearW'(dir_rows[i].yr);
      want.ts.hour = utld_pkg::HourW'(dir_rows[i].eh);
      want.ts.day = utld_pkg::DayW'(dir_rows[i].ed);
      want.ts.month = utld_pkg::MonthW'(dir_rows[i].em);
      want.ts.year = utld_pkg::YearW'(dir_rows[i].ey);
      want.dst = dir_rows[i].edst[0];
      send_word(s, dir_rows[i].typed, want);
    end

    want = '0;
    for (int p = 0; p < NumPhases; p++) begin
      off = (p < 5) ? utld_pkg::OffW'(PhaseOffsets[p])
                    : utld_pkg::OffW'($urandom_range(0, 31));
      load_offset(off);
      for (int n = 0; n < WordsPerPhase; n++) send_word(random_stamp(), 1'b0, want);
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
design/utld_pkg.sv
design/utld_front.sv
design/utld_roll.sv
design/utld_dst.sv
design/utc_to_local_with_dst_core.sv
test/tb_utc_to_local_with_dst_core.sv
